/* src/ccs_pkg.sv */
package ccs_pkg;
   localparam int unsigned DefaultBatch = 32;
   localparam logic [31:0] NominalReset = 32'd150000000;
   localparam logic [23:0] FaultBlinkReset = 24'd100000;
   localparam logic [23:0] StartupBlinkReset = 24'd250000;

   typedef enum logic [1:0] {
      CMD_IDLE = 2'd0,
      CMD_VALID = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_BATCH = 2'd0,
      REG_NOMINAL = 2'd1,
      REG_FAULT_BLINK = 2'd2,
      REG_STARTUP_BLINK = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_BATCH,
      ST_DIV_HZ,
      ST_DIV_PER,
      ST_SHOW,
      ST_OUTPUT
   } state_type;

   // which division the shared divider runs
   typedef enum logic [1:0] {
      DSEL_BATCH = 2'd0,
      DSEL_HZ = 2'd1,
      DSEL_PER = 2'd2,
      DSEL_NONE = 2'd3
   } dsel_type;

   typedef struct packed {
      logic update;
      logic div_start;
      dsel_type div_sel;
      logic capture;
      logic show;
   } cmd_bus_type;

   typedef struct packed {
      logic publish_due;
      logic div_busy;
      logic have_samples;
   } status_bus_type;

   typedef struct packed {
      logic led_on;
      logic pulse_ready;
      logic [31:0] effective_hz;
      logic [31:0] publish_count;
      logic [31:0] valid_count;
      logic [31:0] timeout_count;
      logic [31:0] mean_hz;
      logic [31:0] lowest_hz;
      logic [31:0] highest_hz;
      logic [39:0] mean_period_ns;
      logic [39:0] shortest_period_ns;
      logic [39:0] longest_period_ns;
   } rsp_type;
endpackage

/* src/ccs_if.sv */
interface ccs_req_if import ccs_pkg::*;;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic [47:0] now_us;
   logic [31:0] estimate_hz;
   logic [39:0] pulse_period_ns;
   modport source (output valid, command, now_us, estimate_hz, pulse_period_ns, input ready);
   modport sink (input valid, command, now_us, estimate_hz, pulse_period_ns, output ready);
endinterface

interface ccs_rsp_if import ccs_pkg::*;;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/ccs_divider.sv */
// restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor
module ccs_divider import ccs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy = start || (cnt_ff != 7'd0);
   assign quotient = quo_ff;
endmodule

/* src/ccs_datapath.sv */
module ccs_datapath import ccs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cmd_bus_type    ctl,
   output status_bus_type sts,
   input  logic [1:0]     command,
   input  logic [47:0]    now_us,
   input  logic [31:0]    estimate_hz,
   input  logic [39:0]    pulse_period_ns,
   input  logic           cfg_we,
   input  logic [1:0]     cfg_addr,
   input  logic [31:0]    cfg_data,
   output logic [31:0]    cfg_rdata,
   output rsp_type        result
);
   logic [15:0] bsize_ff, bsize_in;
   logic [31:0] nominal_ff, nominal_in;
   logic [23:0] fblink_ff, fblink_in, sblink_ff, sblink_in;
   logic [47:0] bsum_ff, bsum_in;
   logic [15:0] bcnt_ff, bcnt_in;
   logic [31:0] eff_ff, eff_in, pubs_ff, pubs_in, vtot_ff, vtot_in, ttot_ff, ttot_in;
   logic [63:0] shz_ff, shz_in, sper_ff, sper_in;
   logic [31:0] minhz_ff, minhz_in, maxhz_ff, maxhz_in;
   logic [39:0] minper_ff, minper_in, maxper_ff, maxper_in;
   logic rdy_ff, rdy_in, flt_ff, flt_in, led_ff, led_in;
   logic [47:0] ltt_ff, ltt_in;
   logic [47:0] now_ff, now_in;
   logic [31:0] meanhz_ff, meanhz_in;
   logic [39:0] meanper_ff, meanper_in;
   rsp_type res_ff, res_in;
   logic [63:0] div_dividend, div_q;
   logic [31:0] div_divisor;
   logic div_busy;
   logic [47:0] elapsed;
   logic [23:0] interval;
   logic [15:0] bsize_w;
   cmd_type cmd;

   assign cmd = cmd_type'(command);
   assign elapsed = now_ff - ltt_ff;
   assign bsize_w = (cfg_data[15:0] == 16'd0) ? 16'(DefaultBatch) : cfg_data[15:0];

   // divider operand select
   always_comb begin
      case (ctl.div_sel)
         DSEL_BATCH: begin
            div_dividend = 64'(bsum_ff) + 64'(bcnt_ff[15:1]);
            div_divisor = 32'(bcnt_ff);
         end
         DSEL_HZ: begin
            div_dividend = shz_ff + 64'(vtot_ff[31:1]);
            div_divisor = vtot_ff;
         end
         DSEL_PER: begin
            div_dividend = sper_ff + 64'(vtot_ff[31:1]);
            div_divisor = vtot_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor = 32'd1;
         end
      endcase
   end

   ccs_divider u_div (
      .clock(clock), .reset(reset), .start(ctl.div_start),
      .dividend(div_dividend), .divisor(div_divisor),
      .busy(div_busy), .quotient(div_q)
   );

   // state update
   always_comb begin
      bsize_in = bsize_ff; nominal_in = nominal_ff; fblink_in = fblink_ff;
      sblink_in = sblink_ff; bsum_in = bsum_ff; bcnt_in = bcnt_ff; eff_in = eff_ff;
      pubs_in = pubs_ff; vtot_in = vtot_ff; ttot_in = ttot_ff; shz_in = shz_ff;
      sper_in = sper_ff; minhz_in = minhz_ff; maxhz_in = maxhz_ff;
      minper_in = minper_ff; maxper_in = maxper_ff; rdy_in = rdy_ff; flt_in = flt_ff;
      led_in = led_ff; ltt_in = ltt_ff; meanhz_in = meanhz_ff; meanper_in = meanper_ff;
      now_in = now_ff;
      res_in = res_ff;
      interval = sblink_ff;
      if (cfg_we) begin
         case (reg_index_type'(cfg_addr))
            REG_BATCH: bsize_in = bsize_w;
            REG_NOMINAL: begin
               nominal_in = cfg_data;
               if (pubs_ff == 32'd0) eff_in = cfg_data;
            end
            REG_FAULT_BLINK: fblink_in = cfg_data[23:0];
            REG_STARTUP_BLINK: sblink_in = cfg_data[23:0];
            default: ;
         endcase
      end
      if (ctl.update) begin
         // time of the word kept for the led step
         now_in = now_us;
         case (cmd)
            CMD_TIMEOUT: begin
               ttot_in = ttot_ff + 32'd1;
               rdy_in = 1'b0; bsum_in = '0; bcnt_in = '0; flt_in = 1'b1;
            end
            CMD_VALID: begin
               flt_in = 1'b0; rdy_in = 1'b1;
               bsum_in = bsum_ff + 48'(estimate_hz);
               bcnt_in = bcnt_ff + 16'd1;
               vtot_in = vtot_ff + 32'd1;
               shz_in = shz_ff + 64'(estimate_hz);
               sper_in = sper_ff + 64'(pulse_period_ns);
               if (vtot_ff == 32'd0) begin
                  minhz_in = estimate_hz; maxhz_in = estimate_hz;
                  minper_in = pulse_period_ns; maxper_in = pulse_period_ns;
               end else begin
                  if (estimate_hz < minhz_ff) minhz_in = estimate_hz;
                  if (estimate_hz > maxhz_ff) maxhz_in = estimate_hz;
                  if (pulse_period_ns < minper_ff) minper_in = pulse_period_ns;
                  if (pulse_period_ns > maxper_ff) maxper_in = pulse_period_ns;
               end
            end
            default: ;
         endcase
      end
      // division results
      if (ctl.capture) begin
         case (ctl.div_sel)
            DSEL_BATCH: begin
               eff_in = div_q[31:0];
               pubs_in = pubs_ff + 32'd1;
               bsum_in = '0; bcnt_in = '0;
            end
            DSEL_HZ: meanhz_in = div_q[31:0];
            DSEL_PER: meanper_in = div_q[39:0];
            default: ;
         endcase
      end
      // led and snapshot after all updates
      if (ctl.show) begin
         if (flt_ff || pubs_ff == 32'd0) begin
            interval = flt_ff ? fblink_ff : sblink_ff;
            if (elapsed >= 48'(interval)) begin
               led_in = ~led_ff; ltt_in = now_ff;
            end
         end else begin
            led_in = 1'b1;
         end
         res_in.led_on = led_in;
         res_in.pulse_ready = rdy_ff;
         res_in.effective_hz = eff_ff;
         res_in.publish_count = pubs_ff;
         res_in.valid_count = vtot_ff;
         res_in.timeout_count = ttot_ff;
         if (vtot_ff == 32'd0) begin
            res_in.mean_hz = '0; res_in.lowest_hz = '0; res_in.highest_hz = '0;
            res_in.mean_period_ns = '0; res_in.shortest_period_ns = '0;
            res_in.longest_period_ns = '0;
         end else begin
            res_in.mean_hz = meanhz_ff; res_in.lowest_hz = minhz_ff;
            res_in.highest_hz = maxhz_ff; res_in.mean_period_ns = meanper_ff;
            res_in.shortest_period_ns = minper_ff; res_in.longest_period_ns = maxper_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= 16'(DefaultBatch); nominal_ff <= NominalReset;
         fblink_ff <= FaultBlinkReset; sblink_ff <= StartupBlinkReset;
         bsum_ff <= '0; bcnt_ff <= '0; eff_ff <= NominalReset; pubs_ff <= '0;
         vtot_ff <= '0; ttot_ff <= '0; shz_ff <= '0; sper_ff <= '0;
         minhz_ff <= '0; maxhz_ff <= '0; minper_ff <= '0; maxper_ff <= '0;
         rdy_ff <= 1'b0; flt_ff <= 1'b0; led_ff <= 1'b0; ltt_ff <= '0;
         now_ff <= '0;
      end else begin
         bsize_ff <= bsize_in; nominal_ff <= nominal_in; fblink_ff <= fblink_in;
         sblink_ff <= sblink_in; bsum_ff <= bsum_in; bcnt_ff <= bcnt_in; eff_ff <= eff_in;
         pubs_ff <= pubs_in; vtot_ff <= vtot_in; ttot_ff <= ttot_in; shz_ff <= shz_in;
         sper_ff <= sper_in; minhz_ff <= minhz_in; maxhz_ff <= maxhz_in;
         minper_ff <= minper_in; maxper_ff <= maxper_in; rdy_ff <= rdy_in;
         flt_ff <= flt_in; led_ff <= led_in; ltt_ff <= ltt_in;
         now_ff <= now_in;
      end
      meanhz_ff <= meanhz_in; meanper_ff <= meanper_in; res_ff <= res_in;
   end

   // register readback
   always_comb begin
      case (reg_index_type'(cfg_addr))
         REG_BATCH: cfg_rdata = 32'(bsize_ff);
         REG_NOMINAL: cfg_rdata = nominal_ff;
         REG_FAULT_BLINK: cfg_rdata = 32'(fblink_ff);
         REG_STARTUP_BLINK: cfg_rdata = 32'(sblink_ff);
         default: cfg_rdata = '0;
      endcase
   end

   assign sts.publish_due = (bcnt_ff >= bsize_ff) && (bcnt_ff != 16'd0);
   assign sts.div_busy = div_busy;
   assign sts.have_samples = (vtot_ff != 32'd0);
   assign result = res_ff;

   // a capture from the batch division only follows a due batch
   assert property (@(posedge clock) disable iff (reset)
      ctl.capture && ctl.div_sel == DSEL_BATCH |-> bcnt_ff != 16'd0)
      else $error("batch publish with empty batch");
   // divider never restarted while running
   assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |-> !$past(div_busy) || $past(ctl.capture))
      else $error("divider restarted while busy");
   // batch count cleared after a batch publish
   assert property (@(posedge clock) disable iff (reset)
      ctl.capture && ctl.div_sel == DSEL_BATCH |=> bcnt_ff == 16'd0)
      else $error("batch not cleared on publish");
endmodule

/* src/ccs_control.sv */
module ccs_control import ccs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_ready,
   input  status_bus_type sts,
   output cmd_bus_type    ctl
);
   state_type state_ff, state_in;
   logic started_ff, started_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
      end
   end

   // sequence: update, optional batch divide, two mean divides when samples exist, snapshot, output
   always_comb begin
      state_in = state_ff;
      started_in = 1'b0;
      ctl = '{update: 1'b0, div_start: 1'b0, div_sel: DSEL_NONE, capture: 1'b0, show: 1'b0};
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               ctl.update = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            started_in = 1'b1;
            if (sts.publish_due) begin
               ctl.div_sel = DSEL_BATCH; ctl.div_start = 1'b1; state_in = ST_DIV_BATCH;
            end else if (sts.have_samples) begin
               ctl.div_sel = DSEL_HZ; ctl.div_start = 1'b1; state_in = ST_DIV_HZ;
            end else begin
               state_in = ST_SHOW;
            end
         end
         ST_DIV_BATCH: begin
            ctl.div_sel = DSEL_BATCH;
            if (!sts.div_busy) begin
               ctl.capture = 1'b1; state_in = ST_UPDATE;
            end
         end
         ST_DIV_HZ: begin
            ctl.div_sel = DSEL_HZ;
            if (!sts.div_busy) begin
               ctl.capture = 1'b1; state_in = ST_DIV_PER;
            end
         end
         ST_DIV_PER: begin
            ctl.div_sel = DSEL_PER;
            if (!started_ff) begin
               ctl.div_start = 1'b1; started_in = 1'b1;
            end else if (!sts.div_busy) begin
               ctl.capture = 1'b1; ctl.div_sel = DSEL_PER;
               state_in = ST_SHOW;
            end else begin
               started_in = 1'b1;
            end
            if (state_in == ST_SHOW) begin
               started_in = 1'b0;
            end
         end
         // snapshot once every update and division has landed
         ST_SHOW: begin
            ctl.show = 1'b1;
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* src/clock_stability_statistics.sv */
// from input word to result word: update, a batch division when a batch publishes,
// mean-frequency and mean-period divisions once samples exist, snapshot, output;
// the divisions run one after another on the shared bit-serial divider
// one item at a time: next input taken in the cycle after the result word is taken
// synchronous active-high reset restores register defaults and clears all totals
module clock_stability_statistics import ccs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ccs_req_if.sink     req,
   ccs_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   cmd_bus_type ctl;
   status_bus_type sts;
   logic snap_show;
   logic cfg_we;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;

   ccs_control u_ctl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .sts(sts), .ctl(ctl)
   );

   ccs_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .command(req.command), .now_us(req.now_us), .estimate_hz(req.estimate_hz),
      .pulse_period_ns(req.pulse_period_ns), .cfg_we(cfg_we && csr_paddr[1:0] == 2'b00),
      .cfg_addr(csr_paddr[3:2]), .cfg_data(csr_pwdata), .cfg_rdata(csr_prdata),
      .result(rsp.data)
   );

   assign snap_show = ctl.show;

   // snapshot taken only on the way to the output state
   assert property (@(posedge clock) disable iff (reset)
      snap_show |=> rsp.valid)
      else $error("snapshot without output");
endmodule

/* tb/ccs_checker.sv */
`timescale 1ns / 100ps

module ccs_checker import ccs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ccs_req_if          req,
   ccs_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);

   // shadow of the configuration registers
   logic [15:0] batch_size;
   logic [31:0] nominal_hz;
   logic [23:0] fault_blink;
   logic [23:0] startup_blink;

   // shadow of the block state
   logic [47:0] batch_sum;
   logic [15:0] batch_count;
   logic [31:0] effective_value;
   logic [31:0] publishes;
   logic [31:0] valid_total;
   logic [31:0] timeout_total;
   logic [63:0] sum_hz;
   logic [63:0] sum_period;
   logic [31:0] low_hz, high_hz;
   logic [39:0] low_period, high_period;
   logic        ready_flag, fault_flag, led_level;
   logic [47:0] last_toggle;

   rsp_type expected_snapshots[$];

   task automatic clear_state();
      batch_size = 16'(DefaultBatch);
      nominal_hz = NominalReset;
      fault_blink = FaultBlinkReset;
      startup_blink = StartupBlinkReset;
      batch_sum = '0;
      batch_count = '0;
      effective_value = NominalReset;
      publishes = '0;
      valid_total = '0;
      timeout_total = '0;
      sum_hz = '0;
      sum_period = '0;
      low_hz = '0;
      high_hz = '0;
      low_period = '0;
      high_period = '0;
      ready_flag = 1'b0;
      fault_flag = 1'b0;
      led_level = 1'b0;
      last_toggle = '0;
   endtask

   task automatic write_register(logic [3:0] addr, logic [31:0] value);
      case (reg_index_type'(addr[3:2]))
         REG_BATCH: begin
            batch_size = value[15:0];
            if (batch_size == 0) batch_size = 16'(DefaultBatch);
         end
         REG_NOMINAL: begin
            nominal_hz = value;
            if (publishes == 0) effective_value = value;
         end
         REG_FAULT_BLINK: fault_blink = value[23:0];
         REG_STARTUP_BLINK: startup_blink = value[23:0];
         default: ;
      endcase
   endtask

   // next snapshot from one event word
   function automatic rsp_type predict_snapshot(logic [1:0] command, logic [47:0] now,
                                                logic [31:0] hz, logic [39:0] per);
      rsp_type s;
      logic [47:0] elapsed;
      logic [23:0] interval;
      logic [63:0] quotient;
      logic        blinking;
      s = '0;
      case (cmd_type'(command))
         CMD_TIMEOUT: begin
            timeout_total = timeout_total + 1;
            ready_flag = 1'b0;
            batch_sum = '0;
            batch_count = '0;
            fault_flag = 1'b1;
         end
         CMD_VALID: begin
            fault_flag = 1'b0;
            ready_flag = 1'b1;
            batch_sum = batch_sum + 48'(hz);
            batch_count = batch_count + 1;
            valid_total = valid_total + 1;
            sum_hz = sum_hz + 64'(hz);
            sum_period = sum_period + 64'(per);
            if (valid_total == 1) begin
               low_hz = hz;
               high_hz = hz;
               low_period = per;
               high_period = per;
            end else begin
               if (hz < low_hz) low_hz = hz;
               if (hz > high_hz) high_hz = hz;
               if (per < low_period) low_period = per;
               if (per > high_period) high_period = per;
            end
            if (batch_count >= batch_size && batch_count != 0) begin
               quotient = (64'(batch_sum) + 64'(batch_count / 2)) / 64'(batch_count);
               effective_value = quotient[31:0];
               publishes = publishes + 1;
               batch_sum = '0;
               batch_count = '0;
            end
         end
         default: ;
      endcase

      // led: fast blink on fault, slow blink before first publish, else on
      elapsed = now - last_toggle;
      blinking = 1'b1;
      interval = '0;
      if (fault_flag) interval = fault_blink;
      else if (publishes == 0) interval = startup_blink;
      else begin
         led_level = 1'b1;
         blinking = 1'b0;
      end
      if (blinking && elapsed >= 48'(interval)) begin
         led_level = !led_level;
         last_toggle = now;
      end

      s.led_on = led_level;
      s.pulse_ready = ready_flag;
      s.effective_hz = effective_value;
      s.publish_count = publishes;
      s.valid_count = valid_total;
      s.timeout_count = timeout_total;
      if (valid_total != 0) begin
         quotient = (sum_hz + 64'(valid_total / 2)) / 64'(valid_total);
         s.mean_hz = quotient[31:0];
         quotient = (sum_period + 64'(valid_total / 2)) / 64'(valid_total);
         s.mean_period_ns = quotient[39:0];
         s.lowest_hz = low_hz;
         s.highest_hz = high_hz;
         s.shortest_period_ns = low_period;
         s.longest_period_ns = high_period;
      end
      return s;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report(what, got, want);
   endtask

   initial begin
      errors = 0;
      pending = 0;
      clear_state();
   end

   // watch csr writes, input words and result words
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         clear_state();
         expected_snapshots.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_register(csr_paddr, csr_pwdata);
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (expected_snapshots.size() == 0) begin
               report("unexpected word", 64'(got.valid_count), '0);
            end else begin
               want = expected_snapshots.pop_front();
               check_field("led_on", 64'(got.led_on), 64'(want.led_on));
               check_field("pulse_ready", 64'(got.pulse_ready), 64'(want.pulse_ready));
               check_field("effective_hz", 64'(got.effective_hz), 64'(want.effective_hz));
               check_field("publish_count", 64'(got.publish_count), 64'(want.publish_count));
               check_field("valid_count", 64'(got.valid_count), 64'(want.valid_count));
               check_field("timeout_count", 64'(got.timeout_count), 64'(want.timeout_count));
               check_field("mean_hz", 64'(got.mean_hz), 64'(want.mean_hz));
               check_field("lowest_hz", 64'(got.lowest_hz), 64'(want.lowest_hz));
               check_field("highest_hz", 64'(got.highest_hz), 64'(want.highest_hz));
               check_field("mean_period_ns", 64'(got.mean_period_ns),
                           64'(want.mean_period_ns));
               check_field("shortest_period_ns", 64'(got.shortest_period_ns),
                           64'(want.shortest_period_ns));
               check_field("longest_period_ns", 64'(got.longest_period_ns),
                           64'(want.longest_period_ns));
            end
         end
         if (req.valid && req.ready)
            expected_snapshots.push_back(predict_snapshot(req.command, req.now_us,
                                                          req.estimate_hz,
                                                          req.pulse_period_ns));
      end
      pending <= expected_snapshots.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb import ccs_pkg::*; ;

   localparam int StallLimit = 20000;
   localparam int SettleCycles = 200;
   localparam int HoldCycles = 3000;
   localparam int RandomPerPhase = 320;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors, pending;
   int          sent_count;
   int          quiet_cycles;
   int          burst_left;
   logic [47:0] now_time;

   ccs_req_if req_if ();
   ccs_rsp_if rsp_if ();

   clock_stability_statistics u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ccs_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .errors      (errors),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: runs of ready, random and stalled, plus one long hold-off
   initial begin
      int run_len;
      int mode;
      int held;
      held = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sent_count >= 400) begin
            held = 1;
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         run_len = $urandom_range(1, 60);
         mode = $urandom_range(0, 2);
         repeat (run_len) begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= $urandom_range(0, 1);
               default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // offer one word, hold it until taken, then maybe pause
   task automatic send_word(logic [1:0] command, logic [47:0] now,
                            logic [31:0] hz, logic [39:0] per);
      int gap;
      req_if.valid <= 1'b1;
      req_if.command <= command;
      req_if.now_us <= now;
      req_if.estimate_hz <= hz;
      req_if.pulse_period_ns <= per;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] batch, logic [31:0] nominal,
                             logic [31:0] fault, logic [31:0] startup);
      wait_idle();
      csr_write(REG_NOMINAL, nominal);
      csr_write(REG_BATCH, batch);
      csr_write(REG_FAULT_BLINK, fault);
      csr_write(REG_STARTUP_BLINK, startup);
   endtask

   // random event word; mostly valid samples near the nominal clock
   task automatic send_random();
      logic [1:0]  command;
      logic [31:0] hz;
      logic [39:0] per;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) command = CMD_VALID;
      else if (pick < 85) command = CMD_IDLE;
      else if (pick < 95) command = CMD_TIMEOUT;
      else command = CMD_SPARE;
      pick = $urandom_range(0, 9);
      if (pick == 0) hz = '0;
      else if (pick == 1) hz = '1;
      else if (pick < 4) hz = 32'($urandom);
      else hz = 32'd150000000 + 32'($urandom_range(0, 20000)) - 32'd10000;
      pick = $urandom_range(0, 9);
      if (pick == 0) per = '0;
      else if (pick == 1) per = '1;
      else if (pick < 4) per = 40'({$urandom, $urandom});
      else per = 40'd1000000000 + 40'($urandom_range(0, 2000)) - 40'd1000;
      if ($urandom_range(0, 19) == 0) now_time = 48'({$urandom, $urandom});
      else now_time = now_time + 48'($urandom_range(0, 300000));
      send_word(command, now_time, hz, per);
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.command <= CMD_IDLE;
      req_if.now_us <= '0;
      req_if.estimate_hz <= '0;
      req_if.pulse_period_ns <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      sent_count = 0;
      quiet_cycles = 0;
      burst_left = 1;
      now_time = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no samples, spare code, extremes, time wrap, fault blink
      send_word(CMD_IDLE, 48'd0, 32'd0, 40'd0);
      send_word(CMD_SPARE, 48'd300000, '1, '1);
      send_word(CMD_TIMEOUT, 48'd350000, '0, '0);
      send_word(CMD_IDLE, 48'd500000, '0, '0);
      send_word(CMD_VALID, 48'd600000, 32'd0, 40'd0);
      send_word(CMD_VALID, 48'd700000, '1, '1);
      send_word(CMD_VALID, 48'd800000, 32'd150000000, 40'd1000000000);
      send_word(CMD_VALID, '1, 32'h5555_5555, 40'haa_aaaa_aaaa);
      send_word(CMD_IDLE, 48'd1000, 32'haaaa_aaaa, 40'h55_5555_5555);
      send_word(CMD_TIMEOUT, 48'd2000, '0, '0);
      send_word(CMD_IDLE, 48'd200000, '0, '0);
      send_word(CMD_VALID, 48'hffff_ffff_0000, 32'd149999999, 40'd999999999);
      send_word(CMD_IDLE, 48'h0000_0000_ffff, '0, '0);

      // nominal rewritten before first publish, batch of one, zero intervals
      set_config(32'd1, 32'd0, 32'd0, 32'd0);
      send_word(CMD_VALID, 48'd10, 32'd3, 40'd7);
      send_word(CMD_TIMEOUT, 48'd10, 32'd0, 40'd0);
      send_word(CMD_IDLE, 48'd10, 32'd0, 40'd0);
      repeat (RandomPerPhase) send_random();

      // zero batch selects the default, largest intervals
      set_config(32'd0, 32'hffff_ffff, 32'h00ff_ffff, 32'h00ff_ffff);
      repeat (RandomPerPhase) send_random();

      set_config(32'd65535, $urandom, 32'd1, 32'd1);
      repeat (RandomPerPhase) send_random();

      set_config(32'd3, $urandom, 32'd50000, 32'd120000);
      repeat (RandomPerPhase) send_random();

      // lowered batch size takes effect mid batch
      set_config(32'hffff_0002, $urandom, $urandom_range(1, 400000),
                 $urandom_range(1, 400000));
      repeat (RandomPerPhase) send_random();

      wait_idle();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/ccs_pkg.sv
src/ccs_if.sv
src/ccs_divider.sv
src/ccs_datapath.sv
src/ccs_control.sv
src/clock_stability_statistics.sv
tb/ccs_checker.sv
tb/tb.sv
